@@ rtl/core/clns_pkg.sv @@
// Shared types, constants and the power-up transfer table for the
// character LCD nibble sequencer. No dependencies.
`default_nettype none

package clns_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int INIT_STEPS  = 12;
   localparam int STEP_W      = 4;

   localparam logic [11:0] PULSE_CMD_US  = 12'd4000;
   localparam logic [11:0] PULSE_CHAR_US = 12'd40;

   localparam logic [7:0] DISPLAY_CTRL_BASE = 8'h08;

   typedef enum logic [2:0] {
      OP_INIT      = 3'd0,
      OP_COMMAND   = 3'd1,
      OP_CHARACTER = 3'd2,
      OP_CURSOR    = 3'd3,
      OP_DISPLAY   = 3'd4
   } op_type;

   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] data;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [11:0] pulse;
      logic [14:0] wait_us;
   } xfer_type;

   function automatic xfer_type init_step(input logic [STEP_W-1:0] idx);
      xfer_type x;
      x.rs      = 1'b0;
      x.pulse   = PULSE_CMD_US;
      x.wait_us = 15'd0;
      case (idx)
         4'd0: begin
            x.nibble  = 4'h3;
            x.wait_us = 15'd20000;
         end
         4'd1: begin
            x.nibble  = 4'h3;
            x.wait_us = 15'd5000;
         end
         4'd2: begin
            x.nibble  = 4'h3;
            x.wait_us = 15'd16000;
         end
         4'd3:    x.nibble = 4'h2;
         4'd4:    x.nibble = 4'h2;
         4'd5:    x.nibble = 4'h8;
         4'd6:    x.nibble = 4'h0;
         4'd7:    x.nibble = 4'h6;
         4'd8:    x.nibble = 4'h0;
         4'd9:    x.nibble = 4'hC;
         4'd10:   x.nibble = 4'h0;
         4'd11:   x.nibble = 4'h1;
         default: x.nibble = 4'h0;
      endcase
      return x;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/clns_if.sv @@
// Valid/ready channel interfaces for requests and nibble transfers.
// Depends on nothing.
`default_nettype none

interface clns_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] byte_value;
   logic [2:0] row;
   logic [4:0] column;
   logic       display_on;
   logic       cursor_on;
   logic       blink_on;

   modport source (output valid, opcode, byte_value, row, column,
                   display_on, cursor_on, blink_on, input ready);
   modport sink   (input valid, opcode, byte_value, row, column,
                   display_on, cursor_on, blink_on, output ready);
endinterface

interface clns_rsp_if;
   logic        valid;
   logic        ready;
   logic        register_select;
   logic [3:0]  nibble;
   logic [11:0] pulse_us;
   logic [14:0] wait_before_us;
   logic        last;

   modport source (output valid, register_select, nibble, pulse_us,
                   wait_before_us, last, input ready);
   modport sink   (input valid, register_select, nibble, pulse_us,
                   wait_before_us, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/clns_front.sv @@
// Request decoder: classifies each request into a byte or init job.
// Depends on clns_pkg and clns_req_if.
`default_nettype none

module clns_front (
   clns_req_if.sink          req,
   input  logic              q_ready,
   output clns_pkg::push_type push
);

   function automatic logic [7:0] row_base(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h80;
         2'd1:    b = 8'hC0;
         2'd2:    b = 8'h94;
         default: b = 8'hD4;
      endcase
      return b;
   endfunction

   logic [2:0] row_m1;
   logic [7:0] cursor_addr;

   assign req.ready   = q_ready;
   assign row_m1      = req.row - 3'd1;
   assign cursor_addr = row_base(row_m1[1:0]) + {3'b000, req.column} - 8'd1;

   always_comb begin
      push.job.is_init = 1'b0;
      push.job.rs      = 1'b0;
      push.job.data    = req.byte_value;
      push.valid       = req.valid && q_ready;
      unique case (clns_pkg::op_type'(req.opcode))
         clns_pkg::OP_INIT: begin
            push.job.is_init = 1'b1;
         end
         clns_pkg::OP_COMMAND: begin
         end
         clns_pkg::OP_CHARACTER: begin
            push.job.rs = 1'b1;
         end
         clns_pkg::OP_CURSOR: begin
            push.job.data = cursor_addr;
            if (req.row < 3'd1 || req.row > 3'd4) begin
               push.valid = 1'b0;
            end
         end
         clns_pkg::OP_DISPLAY: begin
            push.job.data = clns_pkg::DISPLAY_CTRL_BASE
                          | {5'b00000, req.display_on, req.cursor_on, req.blink_on};
         end
         default: begin
            push.valid = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/clns_queue.sv @@
// Short job queue between the decoder and the transfer sequencer.
// Depends on clns_pkg.
`default_nettype none

module clns_queue #(
   parameter int Depth = clns_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  clns_pkg::push_type push,
   output logic               q_ready,
   output logic               q_valid,
   output clns_pkg::job_type  q_job,
   input  logic               pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   clns_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign q_ready = count_ff != CntW'(Depth);
   assign q_valid = count_ff != '0;
   assign q_job   = mem_ff[rd_ptr_ff];
   assign do_push = push.valid && q_ready;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/clns_back.sv @@
// Transfer sequencer: expands each job into nibble transfers into an
// output register. Depends on clns_pkg and clns_rsp_if.
`default_nettype none

module clns_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  clns_pkg::job_type q_job,
   output logic              pop,
   clns_rsp_if.source        rsp
);

   logic                        active_ff, active_in;
   logic [clns_pkg::STEP_W-1:0] step_ff, step_in;
   clns_pkg::job_type           job_ff, job_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   clns_pkg::xfer_type          xfer_ff, xfer_in;
   logic                        last_ff, last_in;
   clns_pkg::xfer_type          cur;
   logic                        cur_last;
   logic                        advance;
   logic                        fire;

   always_comb begin
      if (job_ff.is_init) begin
         cur      = clns_pkg::init_step(step_ff);
         cur_last = step_ff == clns_pkg::STEP_W'(clns_pkg::INIT_STEPS - 1);
      end else begin
         cur.rs      = job_ff.rs;
         cur.nibble  = step_ff[0] ? job_ff.data[3:0] : job_ff.data[7:4];
         cur.pulse   = job_ff.rs ? clns_pkg::PULSE_CHAR_US : clns_pkg::PULSE_CMD_US;
         cur.wait_us = 15'd0;
         cur_last    = step_ff[0];
      end
   end

   assign advance = !rsp_valid_ff || rsp.ready;
   assign fire    = active_ff && advance;
   assign pop     = q_valid && (!active_ff || (fire && cur_last));

   always_comb begin
      rsp_valid_in = fire || (rsp_valid_ff && !rsp.ready);
      xfer_in      = fire ? cur : xfer_ff;
      last_in      = fire ? cur_last : last_ff;
      job_in       = pop ? q_job : job_ff;
      if (pop) begin
         active_in = 1'b1;
         step_in   = '0;
      end else if (fire) begin
         active_in = !cur_last && active_ff;
         step_in   = step_ff + 1'b1;
      end else begin
         active_in = active_ff;
         step_in   = step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff  <= job_in;
      xfer_ff <= xfer_in;
      last_ff <= last_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.register_select = xfer_ff.rs;
   assign rsp.nibble          = xfer_ff.nibble;
   assign rsp.pulse_us        = xfer_ff.pulse;
   assign rsp.wait_before_us  = xfer_ff.wait_us;
   assign rsp.last            = last_ff;

endmodule

`default_nettype wire

@@ rtl/core/char_lcd_nibble_sequencer.sv @@
// Character LCD 4-bit bus sequencer: request channel in, nibble transfer
// channel out. Depends on clns_pkg, clns_if, clns_front, clns_queue, clns_back.
//
// Usage:
//   req_ch carries one request word per handshake (opcode and arguments).
//   rsp_ch carries one nibble transfer per word: RS level, nibble, enable
//   pulse width, wait before it, and last on the final transfer of a request.
//   Init gives twelve transfers; command, character, cursor and display
//   control give two; unused opcodes and cursor rows outside 1 to 4 give none.
// A request passes the job queue, job register and output register to rsp_ch.
// Throughput: one transfer per cycle while rsp_ch is ready and a job is
//   queued.
//   Requests are decoded into a job queue of QueueDepth entries, so req_ch
//   keeps accepting while the sequencer works, until the queue is full.
// Reset: synchronous; empties the queue and drops any pending transfer.
// Stall: while rsp_ch is not ready the output word holds and the sequencer
//   stops; req_ch backs up once the queue fills.
`default_nettype none

module char_lcd_nibble_sequencer #(
   parameter int QueueDepth = clns_pkg::QUEUE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   clns_req_if.sink   req_ch,
   clns_rsp_if.source rsp_ch
);

   clns_pkg::push_type push;
   clns_pkg::job_type  q_job;
   logic               q_ready;
   logic               q_valid;
   logic               pop;

   clns_front u_front (
      .req     (req_ch),
      .q_ready (q_ready),
      .push    (push)
   );

   clns_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .q_ready (q_ready),
      .q_valid (q_valid),
      .q_job   (q_job),
      .pop     (pop)
   );

   clns_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_job   (q_job),
      .pop     (pop),
      .rsp     (rsp_ch)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("job popped from empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> q_ready)
      else $error("job pushed into full queue");

   a_char_pulse: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.register_select) |->
         (rsp_ch.pulse_us == clns_pkg::PULSE_CHAR_US && rsp_ch.wait_before_us == 15'd0))
      else $error("character transfer with command timing");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("transfer valid after reset");

endmodule

`default_nettype wire
